// ===== hdl/twhbl_pkg.sv =====
package twhbl_pkg;

   localparam int unsigned PhaseWidth = 4;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned IndexWidth = 3;

   typedef logic [PhaseWidth-1:0] phase_type;
   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [1:0]            req_code_type;

   localparam phase_type PH_IDLE          = 4'd0;
   localparam phase_type PH_TX_CLK_ON     = 4'd1;
   localparam phase_type PH_TX_CLK_OFF    = 4'd2;
   localparam phase_type PH_TX_DATA_ON    = 4'd3;
   localparam phase_type PH_TX_FINAL      = 4'd4;
   localparam phase_type PH_RX_DATA_OFF   = 4'd5;
   localparam phase_type PH_RX_CLK_CHANGE = 4'd6;
   localparam phase_type PH_RX_DATA_ON    = 4'd7;

   localparam req_code_type REQ_SEND = 2'd1;
   localparam req_code_type REQ_RECV = 2'd2;

   localparam byte_type  MSB_MASK  = 8'h80;
   localparam index_type LAST_BIT  = 3'd7;
   localparam index_type FIRST_BIT = 3'd0;

   typedef struct packed {
      logic     drive_clock;
      logic     drive_data;
      logic     busy;
      logic     byte_done;
      byte_type rx_byte;
   } rsp_type;

endpackage

// ===== hdl/two_wire_handshake_byte_link_top.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    type, tx_byte, clock/data line samples
// rsp_      out        rsp_valid/rsp_ready    drives, busy, done, rx_byte
//
// One request per cycle sustained while rsp_ready keeps taking responses; an accepted
// request loads the input register, and its response then loads the response register.
// The bus state machine advances once per request, between those two registers.
// Reset is synchronous: idle, clock driven asserted, data released.
// A held response stalls the pipeline; req_ready drops only when both stages are full.
module two_wire_handshake_byte_link_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_tx_byte,
   input  logic       req_clock_line_asserted,
   input  logic       req_data_line_asserted,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_clock,
   output logic       rsp_drive_data,
   output logic       rsp_busy_res,
   output logic       rsp_byte_done,
   output logic [7:0] rsp_rx_byte
);

   logic                    in_valid_ff;
   twhbl_pkg::req_code_type in_type_ff;
   twhbl_pkg::byte_type     in_tx_byte_ff;
   logic                    in_clk_ff;
   logic                    in_dat_ff;
   logic                    out_valid_ff;
   twhbl_pkg::rsp_type      out_ff;
   twhbl_pkg::rsp_type      step_rsp;
   logic                    out_free;
   logic                    step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   twhbl_fsm u_fsm (
      .clock               (clock),
      .reset               (reset),
      .step                (step),
      .req_type            (in_type_ff),
      .tx_byte             (in_tx_byte_ff),
      .clock_line_asserted (in_clk_ff),
      .data_line_asserted  (in_dat_ff),
      .rsp                 (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_type_ff    <= req_type;
         in_tx_byte_ff <= req_tx_byte;
         in_clk_ff     <= req_clock_line_asserted;
         in_dat_ff     <= req_data_line_asserted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_clock = out_ff.drive_clock;
   assign rsp_drive_data  = out_ff.drive_data;
   assign rsp_busy_res    = out_ff.busy;
   assign rsp_byte_done   = out_ff.byte_done;
   assign rsp_rx_byte     = out_ff.rx_byte;

endmodule

// ===== hdl/twhbl_fsm.sv =====
module twhbl_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  twhbl_pkg::req_code_type req_type,
   input  twhbl_pkg::byte_type    tx_byte,
   input  logic                   clock_line_asserted,
   input  logic                   data_line_asserted,
   output twhbl_pkg::rsp_type     rsp
);

   twhbl_pkg::phase_type phase_ff, phase_in;
   twhbl_pkg::index_type bit_index_ff, bit_index_in;
   twhbl_pkg::byte_type  shift_byte_ff, shift_byte_in;
   logic                 sampled_bit_ff, sampled_bit_in;
   logic                 clock_drive_ff, clock_drive_in;
   logic                 data_drive_ff, data_drive_in;
   logic                 done;
   twhbl_pkg::byte_type  rx_out;
   twhbl_pkg::index_type next_index;

   assign next_index = bit_index_ff - 3'd1;

   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      sampled_bit_in = sampled_bit_ff;
      clock_drive_in = clock_drive_ff;
      data_drive_in  = data_drive_ff;
      done           = 1'b0;
      rx_out         = '0;
      unique case (phase_ff)
         twhbl_pkg::PH_IDLE: begin
            if (req_type == twhbl_pkg::REQ_SEND) begin
               shift_byte_in  = tx_byte;
               bit_index_in   = twhbl_pkg::LAST_BIT;
               data_drive_in  = tx_byte[twhbl_pkg::LAST_BIT];
               clock_drive_in = 1'b0;
               phase_in       = twhbl_pkg::PH_TX_CLK_ON;
            end else if (req_type == twhbl_pkg::REQ_RECV) begin
               shift_byte_in  = '0;
               bit_index_in   = twhbl_pkg::LAST_BIT;
               clock_drive_in = 1'b0;
               phase_in       = twhbl_pkg::PH_RX_DATA_OFF;
            end
         end
         twhbl_pkg::PH_TX_CLK_ON: begin
            if (clock_line_asserted) begin
               data_drive_in = ~shift_byte_ff[bit_index_ff];
               phase_in      = twhbl_pkg::PH_TX_CLK_OFF;
            end
         end
         twhbl_pkg::PH_TX_CLK_OFF: begin
            if (!clock_line_asserted) begin
               data_drive_in  = 1'b0;
               clock_drive_in = 1'b1;
               phase_in       = (bit_index_ff == twhbl_pkg::FIRST_BIT) ?
                                twhbl_pkg::PH_TX_FINAL : twhbl_pkg::PH_TX_DATA_ON;
            end
         end
         twhbl_pkg::PH_TX_DATA_ON: begin
            if (data_line_asserted) begin
               bit_index_in   = next_index;
               data_drive_in  = shift_byte_ff[next_index];
               clock_drive_in = 1'b0;
               phase_in       = twhbl_pkg::PH_TX_CLK_ON;
            end
         end
         twhbl_pkg::PH_TX_FINAL: begin
            if (data_line_asserted) begin
               done     = 1'b1;
               phase_in = twhbl_pkg::PH_IDLE;
            end
         end
         twhbl_pkg::PH_RX_DATA_OFF: begin
            if (!data_line_asserted) begin
               sampled_bit_in = clock_line_asserted;
               shift_byte_in  = (shift_byte_ff >> 1) |
                                (clock_line_asserted ? twhbl_pkg::MSB_MASK : '0);
               data_drive_in  = 1'b1;
               phase_in       = twhbl_pkg::PH_RX_CLK_CHANGE;
            end
         end
         twhbl_pkg::PH_RX_CLK_CHANGE: begin
            if (clock_line_asserted != sampled_bit_ff) begin
               clock_drive_in = 1'b1;
               data_drive_in  = 1'b0;
               phase_in       = twhbl_pkg::PH_RX_DATA_ON;
            end
         end
         twhbl_pkg::PH_RX_DATA_ON: begin
            if (data_line_asserted) begin
               if (bit_index_ff == twhbl_pkg::FIRST_BIT) begin
                  done     = 1'b1;
                  rx_out   = shift_byte_ff;
                  phase_in = twhbl_pkg::PH_IDLE;
               end else begin
                  bit_index_in   = next_index;
                  clock_drive_in = 1'b0;
                  phase_in       = twhbl_pkg::PH_RX_DATA_OFF;
               end
            end
         end
         default: begin
            phase_in = twhbl_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= twhbl_pkg::PH_IDLE;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         sampled_bit_ff <= 1'b0;
         clock_drive_ff <= 1'b1;
         data_drive_ff  <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         sampled_bit_ff <= sampled_bit_in;
         clock_drive_ff <= clock_drive_in;
         data_drive_ff  <= data_drive_in;
      end
   end

   assign rsp.drive_clock = clock_drive_in;
   assign rsp.drive_data  = data_drive_in;
   assign rsp.busy        = (phase_in != twhbl_pkg::PH_IDLE);
   assign rsp.byte_done   = done;
   assign rsp.rx_byte     = rx_out;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam twhbl_pkg::req_code_type REQ_TICK  = 2'd0;
   localparam twhbl_pkg::req_code_type REQ_SPARE = 2'd3;
   localparam int unsigned TOTAL_ITEMS = 1050;
   localparam int unsigned DIR_ROWS    = 9;
   localparam int unsigned TAIL_CYCLES = 12;

   localparam twhbl_pkg::rsp_type IDLE_RSP    = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
   localparam twhbl_pkg::rsp_type TX_MSB1_RSP = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00};

   typedef struct {
      twhbl_pkg::req_code_type code;
      twhbl_pkg::byte_type     tx;
      logic                    clk;
      logic                    dat;
      logic                    typed;
      twhbl_pkg::rsp_type      want;
   } request_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_type;
   logic [7:0] req_tx_byte;
   logic       req_clock_line_asserted;
   logic       req_data_line_asserted;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_drive_clock;
   logic       rsp_drive_data;
   logic       rsp_busy_res;
   logic       rsp_byte_done;
   logic [7:0] rsp_rx_byte;

   request_row_type    dir_rows [DIR_ROWS];
   twhbl_pkg::rsp_type bus_response_q [$];

   twhbl_pkg::phase_type link_phase;
   twhbl_pkg::index_type link_index;
   twhbl_pkg::byte_type  link_shift;
   logic                 link_sampled;
   logic                 link_clk_drv;
   logic                 link_dat_drv;

   int unsigned accepted_cnt;
   int unsigned mismatch_cnt;
   int unsigned send_gap;
   int unsigned ready_hold;
   logic        burst;

   two_wire_handshake_byte_link_top DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_type                (req_type),
      .req_tx_byte             (req_tx_byte),
      .req_clock_line_asserted (req_clock_line_asserted),
      .req_data_line_asserted  (req_data_line_asserted),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_drive_clock         (rsp_drive_clock),
      .rsp_drive_data          (rsp_drive_data),
      .rsp_busy_res            (rsp_busy_res),
      .rsp_byte_done           (rsp_byte_done),
      .rsp_rx_byte             (rsp_rx_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_type                = REQ_TICK;
      req_tx_byte             = 8'h00;
      req_clock_line_asserted = 1'b0;
      req_data_line_asserted  = 1'b0;
      rsp_ready               = 1'b0;
      mismatch_cnt            = 0;
      dir_rows[0] = '{REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b1, IDLE_RSP};
      dir_rows[1] = '{REQ_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1, IDLE_RSP};
      dir_rows[2] = '{twhbl_pkg::REQ_SEND, 8'h80, 1'b0, 1'b0, 1'b1, TX_MSB1_RSP};
      dir_rows[3] = '{twhbl_pkg::REQ_RECV, 8'h00, 1'b0, 1'b1, 1'b0, '0};
      dir_rows[4] = '{REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0, '0};
      dir_rows[5] = '{twhbl_pkg::REQ_SEND, 8'hFF, 1'b1, 1'b1, 1'b0, '0};
      dir_rows[6] = '{REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b0, '0};
      dir_rows[7] = '{REQ_SPARE, 8'h55, 1'b0, 1'b0, 1'b0, '0};
      dir_rows[8] = '{REQ_TICK,  8'hAA, 1'b0, 1'b1, 1'b0, '0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic reset_link();
      link_phase   = twhbl_pkg::PH_IDLE;
      link_index   = twhbl_pkg::FIRST_BIT;
      link_shift   = '0;
      link_sampled = 1'b0;
      link_clk_drv = 1'b1;
      link_dat_drv = 1'b0;
   endtask

   function automatic twhbl_pkg::rsp_type bus_fsm_step(twhbl_pkg::req_code_type code,
                                                       twhbl_pkg::byte_type tx,
                                                       logic clk, logic dat);
      twhbl_pkg::rsp_type r;
      r = '0;
      case (link_phase)
         twhbl_pkg::PH_IDLE: begin
            if (code == twhbl_pkg::REQ_SEND) begin
               link_shift   = tx;
               link_index   = twhbl_pkg::LAST_BIT;
               link_dat_drv = tx[twhbl_pkg::LAST_BIT];
               link_clk_drv = 1'b0;
               link_phase   = twhbl_pkg::PH_TX_CLK_ON;
            end else if (code == twhbl_pkg::REQ_RECV) begin
               link_shift   = '0;
               link_index   = twhbl_pkg::LAST_BIT;
               link_clk_drv = 1'b0;
               link_phase   = twhbl_pkg::PH_RX_DATA_OFF;
            end
         end
         twhbl_pkg::PH_TX_CLK_ON: begin
            if (clk) begin
               link_dat_drv = ~link_shift[link_index];
               link_phase   = twhbl_pkg::PH_TX_CLK_OFF;
            end
         end
         twhbl_pkg::PH_TX_CLK_OFF: begin
            if (!clk) begin
               link_dat_drv = 1'b0;
               link_clk_drv = 1'b1;
               link_phase   = (link_index == twhbl_pkg::FIRST_BIT) ?
                              twhbl_pkg::PH_TX_FINAL : twhbl_pkg::PH_TX_DATA_ON;
            end
         end
         twhbl_pkg::PH_TX_DATA_ON: begin
            if (dat) begin
               link_index   = link_index - 1'b1;
               link_dat_drv = link_shift[link_index];
               link_clk_drv = 1'b0;
               link_phase   = twhbl_pkg::PH_TX_CLK_ON;
            end
         end
         twhbl_pkg::PH_TX_FINAL: begin
            if (dat) begin
               r.byte_done = 1'b1;
               link_phase  = twhbl_pkg::PH_IDLE;
            end
         end
         twhbl_pkg::PH_RX_DATA_OFF: begin
            if (!dat) begin
               link_sampled = clk;
               link_shift   = {clk, link_shift[twhbl_pkg::ByteWidth-1:1]};
               link_dat_drv = 1'b1;
               link_phase   = twhbl_pkg::PH_RX_CLK_CHANGE;
            end
         end
         twhbl_pkg::PH_RX_CLK_CHANGE: begin
            if (clk != link_sampled) begin
               link_clk_drv = 1'b1;
               link_dat_drv = 1'b0;
               link_phase   = twhbl_pkg::PH_RX_DATA_ON;
            end
         end
         twhbl_pkg::PH_RX_DATA_ON: begin
            if (dat) begin
               if (link_index == twhbl_pkg::FIRST_BIT) begin
                  r.byte_done = 1'b1;
                  r.rx_byte   = link_shift;
                  link_phase  = twhbl_pkg::PH_IDLE;
               end else begin
                  link_index   = link_index - 1'b1;
                  link_clk_drv = 1'b0;
                  link_phase   = twhbl_pkg::PH_RX_DATA_OFF;
               end
            end
         end
         default: link_phase = twhbl_pkg::PH_IDLE;
      endcase
      r.drive_clock = link_clk_drv;
      r.drive_data  = link_dat_drv;
      r.busy        = (link_phase != twhbl_pkg::PH_IDLE);
      return r;
   endfunction

   task automatic load_request(int unsigned idx);
      twhbl_pkg::req_code_type code;
      twhbl_pkg::byte_type     tx;
      logic                    clk;
      logic                    dat;
      if (idx < DIR_ROWS) begin
         code = dir_rows[idx].code;
         tx   = dir_rows[idx].tx;
         clk  = dir_rows[idx].clk;
         dat  = dir_rows[idx].dat;
      end else begin
         code = twhbl_pkg::req_code_type'($urandom_range(0, 3));
         tx   = twhbl_pkg::byte_type'($urandom);
         clk  = 1'($urandom_range(0, 1));
         dat  = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: tx = 8'h00;
            1: tx = 8'hFF;
            default: ;
         endcase
         if (link_phase == twhbl_pkg::PH_IDLE && $urandom_range(0, 9) != 0)
            code = $urandom_range(0, 1) ? twhbl_pkg::REQ_SEND : twhbl_pkg::REQ_RECV;
         if ($urandom_range(0, 3) != 0) begin
            case (link_phase)
               twhbl_pkg::PH_TX_CLK_ON:     clk = 1'b1;
               twhbl_pkg::PH_TX_CLK_OFF:    clk = 1'b0;
               twhbl_pkg::PH_TX_DATA_ON,
               twhbl_pkg::PH_TX_FINAL,
               twhbl_pkg::PH_RX_DATA_ON:    dat = 1'b1;
               twhbl_pkg::PH_RX_DATA_OFF:   dat = 1'b0;
               twhbl_pkg::PH_RX_CLK_CHANGE: clk = ~link_sampled;
               default: ;
            endcase
         end
      end
      req_type                <= code;
      req_tx_byte             <= tx;
      req_clock_line_asserted <= clk;
      req_data_line_asserted  <= dat;
   endtask

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      mismatch_cnt++;
   endtask

   always @(posedge clock) begin
      twhbl_pkg::rsp_type r;
      if (reset) begin
         reset_link();
         req_valid    <= 1'b0;
         accepted_cnt = 0;
         send_gap     = 0;
         burst        = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r = bus_fsm_step(req_type, req_tx_byte, req_clock_line_asserted,
                             req_data_line_asserted);
            if (accepted_cnt < DIR_ROWS && dir_rows[accepted_cnt].typed)
               r = dir_rows[accepted_cnt].want;
            bus_response_q.push_back(r);
            accepted_cnt++;
            if ($urandom_range(0, 59) == 0)
               burst = ~burst;
            send_gap = burst ? 0 : $urandom_range(0, 9);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || accepted_cnt >= TOTAL_ITEMS) begin
               req_valid <= 1'b0;
               if (send_gap > 0)
                  send_gap--;
            end else begin
               load_request(accepted_cnt);
               req_valid <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      twhbl_pkg::rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bus_response_q.size() == 0) begin
               report_mismatch("unexpected request", 1, 0);
            end else begin
               want = bus_response_q.pop_front();
               if (rsp_drive_clock !== want.drive_clock)
                  report_mismatch("drive_clock", rsp_drive_clock, want.drive_clock);
               if (rsp_drive_data !== want.drive_data)
                  report_mismatch("drive_data", rsp_drive_data, want.drive_data);
               if (rsp_busy_res !== want.busy)
                  report_mismatch("busy_res", rsp_busy_res, want.busy);
               if (rsp_byte_done !== want.byte_done)
                  report_mismatch("byte_done", rsp_byte_done, want.byte_done);
               if (rsp_rx_byte !== want.rx_byte)
                  report_mismatch("rx_byte", rsp_rx_byte, want.rx_byte);
            end
            ready_hold = burst ? 0 : $urandom_range(0, 9);
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      @(negedge reset);
      while (accepted_cnt < TOTAL_ITEMS || bus_response_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bus_response_q.size() != 0)
         report_mismatch("requests left pending", bus_response_q.size(), 0);
      if (mismatch_cnt == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/twhbl_pkg.sv
hdl/twhbl_fsm.sv
hdl/two_wire_handshake_byte_link_top.sv
tb/testbench.sv
